@@ sv/dtfp_pkg.sv @@
// ----------------------------------------------------------------------------
// dtfp_pkg: shared definitions for the decimal text to fixed point block
// Widths, character codes, divider constants and the result snapshot type.
// ----------------------------------------------------------------------------
package dtfp_pkg;

    localparam int CH_BITS        = 8;
    localparam int POSITION_BITS  = 16;
    localparam int STOP_BITS      = 16;
    localparam int INT_BITS       = 15;
    localparam int FRAC_BITS      = 27;
    localparam int DIGIT_CNT_BITS = 4;
    localparam int QUO_BITS       = 16;
    localparam int VALUE_BITS     = 32;

    localparam logic [INT_BITS-1:0]       INT_LIMIT       = 15'd32767;
    localparam logic [DIGIT_CNT_BITS-1:0] FRAC_DIGITS_MAX = 4'd8;
    localparam logic [STOP_BITS-1:0]      STOP_MAX        = 16'hFFFF;

    // Scaled fraction / 1526 == (x * RECIP_M) >> RECIP_SHIFT for all x < 2^27
    localparam int                   RECIP_BITS  = 28;
    localparam int                   RECIP_SHIFT = 38;
    localparam logic [RECIP_BITS-1:0] RECIP_M    = 28'd180129691;
    localparam logic [FRAC_BITS-1:0] SCALED_LIMIT = 27'd100000000;
    localparam logic [QUO_BITS-1:0]  QUO_MAX     = 16'd65530;

    // Character codes
    localparam logic [CH_BITS-1:0] CH_NUL   = 8'd0;
    localparam logic [CH_BITS-1:0] CH_TAB   = 8'd9;
    localparam logic [CH_BITS-1:0] CH_CR    = 8'd13;
    localparam logic [CH_BITS-1:0] CH_SPACE = 8'd32;
    localparam logic [CH_BITS-1:0] CH_PLUS  = 8'd43;
    localparam logic [CH_BITS-1:0] CH_MINUS = 8'd45;
    localparam logic [CH_BITS-1:0] CH_POINT = 8'd46;
    localparam logic [CH_BITS-1:0] CH_ZERO  = 8'd48;
    localparam logic [CH_BITS-1:0] CH_NINE  = 8'd57;

    // Parser state captured at the character that ends parsing
    typedef struct packed {
        logic [INT_BITS-1:0]       int_part;
        logic [FRAC_BITS-1:0]      frac;
        logic [DIGIT_CNT_BITS-1:0] digits;
        logic                      neg;
        logic [STOP_BITS-1:0]      pos;
        logic                      early;
    } t_snap;

    // Multiplier that scales the fraction accumulator to eight digits
    function automatic logic [FRAC_BITS-1:0] frac_scale(input logic [DIGIT_CNT_BITS-1:0] digits);
        logic [FRAC_BITS-1:0] s;
        unique case (digits)
            4'd0:    s = 27'd100000000;
            4'd1:    s = 27'd10000000;
            4'd2:    s = 27'd1000000;
            4'd3:    s = 27'd100000;
            4'd4:    s = 27'd10000;
            4'd5:    s = 27'd1000;
            4'd6:    s = 27'd100;
            4'd7:    s = 27'd10;
            default: s = 27'd1;
        endcase
        return s;
    endfunction

    // Limit a position count to the width of the result field
    function automatic logic [STOP_BITS-1:0] clamp_pos(input logic [POSITION_BITS-1:0] p);
        logic [POSITION_BITS+STOP_BITS-1:0] w;
        logic [STOP_BITS-1:0]               r;
        w = (POSITION_BITS+STOP_BITS)'(p);
        if (w > (POSITION_BITS+STOP_BITS)'(STOP_MAX)) begin
            r = STOP_MAX;
        end else begin
            r = w[STOP_BITS-1:0];
        end
        return r;
    endfunction

endpackage

@@ sv/dtfp_in_if.sv @@
// ----------------------------------------------------------------------------
// dtfp_in_if: character channel
// Valid/ready channel that carries one text character and its end marker.
// ----------------------------------------------------------------------------
interface dtfp_in_if;
    logic                          valid;
    logic                          ready;
    logic [dtfp_pkg::CH_BITS-1:0]  ch;
    logic                          last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

@@ sv/dtfp_out_if.sv @@
// ----------------------------------------------------------------------------
// dtfp_out_if: result channel
// Valid/ready channel that carries the parsed value and the stop position.
// ----------------------------------------------------------------------------
interface dtfp_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [dtfp_pkg::VALUE_BITS-1:0] value;
    logic [dtfp_pkg::STOP_BITS-1:0]         stop_position;
    logic                                   stopped_early;

    modport source (output valid, output value, output stop_position,
                    output stopped_early, input ready);
    modport sink   (input valid, input value, input stop_position,
                    input stopped_early, output ready);
endinterface

@@ sv/decimal_text_to_fixed_point.sv @@
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point: decimal text to signed 16.16 fixed point
// Character-serial parser with a four-stage result pipeline.
// ----------------------------------------------------------------------------
// The block takes one ASCII character per transaction on i_in and returns one
// signed 16.16 value per string on o_out, at the first illegal character, at
// a NUL, or at the character marked last. Leading white space is skipped, one
// sign and then one decimal point are allowed, the integer part saturates at
// 32767 and only the first eight fraction digits count. A character is taken
// every cycle as long as the result pipeline can move; the parser updates its
// accumulators on each accepted character. The result for a string passes
// through the capture register, which loads with the transaction that ends
// parsing, then the fraction scaling multiply, the reciprocal multiply for
// the divide by 1526, and the sign and output register that drives o_out.
// Back-pressure on o_out holds the pipeline, and i_in.ready drops only once
// all four stages are full. stop_position saturates at 65535.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_point (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dtfp_in_if.sink    i_in,
    dtfp_out_if.source o_out
);

    logic            accept;     // character transaction completes
    logic            emit;       // this character ends parsing
    logic            snap_ready; // result pipeline can take a capture
    dtfp_pkg::t_snap snap;

    // Ready does not depend on the character: hold it off only when the
    // result pipeline is full, so a stopping character is never lost.
    assign i_in.ready = snap_ready;
    assign accept     = i_in.valid && snap_ready;

    // Parser: skips white space, tracks sign, point and digit counts, and
    // captures its state when parsing stops.
    dtfp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_ch     (i_in.ch),
        .i_last   (i_in.last),
        .o_emit   (emit),
        .o_snap   (snap)
    );

    // Result pipeline: advance a capture only on the cycle it was produced.
    dtfp_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (emit),
        .i_snap       (snap),
        .o_snap_ready (snap_ready),
        .o_out        (o_out)
    );

endmodule

@@ sv/dtfp_parse.sv @@
// ----------------------------------------------------------------------------
// dtfp_parse: character parser
// Per-character state update and capture of the state when parsing stops.
// ----------------------------------------------------------------------------
module dtfp_parse (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [dtfp_pkg::CH_BITS-1:0] i_ch,
    input  logic                         i_last,
    output logic                         o_emit,
    output dtfp_pkg::t_snap              o_snap
);

    logic [dtfp_pkg::INT_BITS-1:0]       r_int,    n_int;
    logic [dtfp_pkg::FRAC_BITS-1:0]      r_frac,   n_frac;
    logic [dtfp_pkg::DIGIT_CNT_BITS-1:0] r_digits, n_digits;
    logic                                r_point,  n_point;
    logic                                r_neg,    n_neg;
    logic                                r_first,  n_first;
    logic                                r_done,   n_done;
    logic [dtfp_pkg::POSITION_BITS-1:0]  r_pos,    n_pos;

    logic [dtfp_pkg::POSITION_BITS-1:0]  pos_inc;
    logic [dtfp_pkg::POSITION_BITS-1:0]  emit_pos;
    logic [dtfp_pkg::CH_BITS-1:0]        ch_off;
    logic [3:0]                          digit;
    logic [dtfp_pkg::INT_BITS+3:0]       int_t;
    logic                                is_ws;
    logic                                is_digit;
    logic                                legal;
    logic                                early;
    logic                                clear;

    always_comb begin
        pos_inc  = (r_pos == '1) ? r_pos : r_pos + 1'b1;
        ch_off   = i_ch - dtfp_pkg::CH_ZERO;
        digit    = ch_off[3:0];
        int_t    = (dtfp_pkg::INT_BITS+4)'(r_int) * (dtfp_pkg::INT_BITS+4)'(10)
                 + (dtfp_pkg::INT_BITS+4)'(digit);
        is_ws    = r_first && (i_ch == dtfp_pkg::CH_SPACE ||
                   (i_ch >= dtfp_pkg::CH_TAB && i_ch <= dtfp_pkg::CH_CR));
        is_digit = (i_ch >= dtfp_pkg::CH_ZERO) && (i_ch <= dtfp_pkg::CH_NINE);
        legal    = (r_first && (i_ch == dtfp_pkg::CH_MINUS || i_ch == dtfp_pkg::CH_PLUS))
                || (!r_first && !r_point && i_ch == dtfp_pkg::CH_POINT)
                || is_digit;

        n_int    = r_int;
        n_frac   = r_frac;
        n_digits = r_digits;
        n_point  = r_point;
        n_neg    = r_neg;
        n_first  = r_first;
        n_done   = r_done;
        n_pos    = r_pos;
        o_emit   = 1'b0;
        early    = 1'b0;
        clear    = 1'b0;
        emit_pos = r_pos;

        if (i_accept) begin
            if (r_done) begin
                // drop everything up to the end of the string
                clear = i_last;
            end else if (i_ch == dtfp_pkg::CH_NUL) begin
                o_emit = 1'b1;
                clear  = i_last;
                n_done = !i_last;
            end else if (is_ws) begin
                n_pos = pos_inc;
                if (i_last) begin
                    o_emit   = 1'b1;
                    emit_pos = pos_inc;
                    clear    = 1'b1;
                end
            end else if (legal) begin
                if (r_first && i_ch == dtfp_pkg::CH_MINUS) begin
                    n_neg = 1'b1;
                end else if (r_first && i_ch == dtfp_pkg::CH_PLUS) begin
                    n_neg = 1'b0;
                end else if (!is_digit) begin
                    n_point = 1'b1;
                end else if (!r_point) begin
                    n_int = (int_t > (dtfp_pkg::INT_BITS+4)'(dtfp_pkg::INT_LIMIT))
                          ? dtfp_pkg::INT_LIMIT : int_t[dtfp_pkg::INT_BITS-1:0];
                end else if (r_digits < dtfp_pkg::FRAC_DIGITS_MAX) begin
                    n_frac   = dtfp_pkg::FRAC_BITS'(r_frac * dtfp_pkg::FRAC_BITS'(10))
                             + dtfp_pkg::FRAC_BITS'(digit);
                    n_digits = r_digits + 1'b1;
                end
                n_first = 1'b0;
                n_pos   = pos_inc;
                if (i_last) begin
                    o_emit   = 1'b1;
                    emit_pos = pos_inc;
                    clear    = 1'b1;
                end
            end else begin
                o_emit = 1'b1;
                early  = 1'b1;
                clear  = i_last;
                n_done = !i_last;
            end
        end

        o_snap.int_part = n_int;
        o_snap.frac     = n_frac;
        o_snap.digits   = n_digits;
        o_snap.neg      = n_neg;
        o_snap.pos      = dtfp_pkg::clamp_pos(emit_pos);
        o_snap.early    = early;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear) begin
            r_int    <= '0;
            r_frac   <= '0;
            r_digits <= '0;
            r_point  <= 1'b0;
            r_neg    <= 1'b0;
            r_first  <= 1'b1;
            r_done   <= 1'b0;
            r_pos    <= '0;
        end else begin
            r_int    <= n_int;
            r_frac   <= n_frac;
            r_digits <= n_digits;
            r_point  <= n_point;
            r_neg    <= n_neg;
            r_first  <= n_first;
            r_done   <= n_done;
            r_pos    <= n_pos;
        end
    end

    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !o_emit)
        else $error("result produced after parsing already stopped");

    a_first_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_first |-> (r_int == '0 && r_frac == '0 && r_digits == '0 && !r_point))
        else $error("accumulators not clear before first character");

    a_digits_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_digits <= dtfp_pkg::FRAC_DIGITS_MAX) && (r_point || r_digits == '0))
        else $error("fraction digit count out of range");

endmodule

@@ sv/dtfp_scale.sv @@
// ----------------------------------------------------------------------------
// dtfp_scale: result pipeline
// Scale the fraction, divide by the fixed divisor and apply the sign.
// ----------------------------------------------------------------------------
module dtfp_scale (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_snap_valid,
    input  dtfp_pkg::t_snap   i_snap,
    output logic              o_snap_ready,
    dtfp_out_if.source        o_out
);

    localparam int SCALE_PROD_BITS = 2 * dtfp_pkg::FRAC_BITS;
    localparam int DIV_PROD_BITS   = dtfp_pkg::FRAC_BITS + dtfp_pkg::RECIP_BITS;
    localparam int MAG_BITS        = dtfp_pkg::INT_BITS + dtfp_pkg::QUO_BITS;

    // stage 1: captured parser state
    logic                                  r1_v;
    dtfp_pkg::t_snap                       r1_snap;
    // stage 2: fraction scaled to eight digits
    logic                                  r2_v;
    logic [dtfp_pkg::FRAC_BITS-1:0]        r2_scaled;
    logic [dtfp_pkg::INT_BITS-1:0]         r2_int;
    logic                                  r2_neg;
    logic [dtfp_pkg::STOP_BITS-1:0]        r2_pos;
    logic                                  r2_early;
    // stage 3: fraction bits
    logic                                  r3_v;
    logic [dtfp_pkg::QUO_BITS-1:0]         r3_quo;
    logic [dtfp_pkg::INT_BITS-1:0]         r3_int;
    logic                                  r3_neg;
    logic [dtfp_pkg::STOP_BITS-1:0]        r3_pos;
    logic                                  r3_early;
    // stage 4: output register
    logic                                  r4_v;
    logic signed [dtfp_pkg::VALUE_BITS-1:0] r4_value;
    logic [dtfp_pkg::STOP_BITS-1:0]        r4_pos;
    logic                                  r4_early;

    logic                                  adv1, adv2, adv3, adv4;
    logic [SCALE_PROD_BITS-1:0]            scale_prod;
    logic [DIV_PROD_BITS-1:0]              div_prod;
    logic [dtfp_pkg::VALUE_BITS-1:0]       mag;
    logic [dtfp_pkg::VALUE_BITS-1:0]       n_value;

    always_comb begin
        adv4 = !r4_v || o_out.ready;
        adv3 = !r3_v || adv4;
        adv2 = !r2_v || adv3;
        adv1 = !r1_v || adv2;

        scale_prod = SCALE_PROD_BITS'(r1_snap.frac)
                   * SCALE_PROD_BITS'(dtfp_pkg::frac_scale(r1_snap.digits));
        div_prod   = DIV_PROD_BITS'(r2_scaled) * DIV_PROD_BITS'(dtfp_pkg::RECIP_M);
        mag        = dtfp_pkg::VALUE_BITS'({r3_int, r3_quo});
        n_value    = r3_neg ? (dtfp_pkg::VALUE_BITS'(0) - mag) : mag;
    end

    assign o_snap_ready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (adv1) r1_v <= i_snap_valid;
            if (adv2) r2_v <= r1_v;
            if (adv3) r3_v <= r2_v;
            if (adv4) r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r1_snap <= i_snap;
        end
        if (adv2) begin
            r2_scaled <= scale_prod[dtfp_pkg::FRAC_BITS-1:0];
            r2_int    <= r1_snap.int_part;
            r2_neg    <= r1_snap.neg;
            r2_pos    <= r1_snap.pos;
            r2_early  <= r1_snap.early;
        end
        if (adv3) begin
            r3_quo   <= div_prod[dtfp_pkg::RECIP_SHIFT +: dtfp_pkg::QUO_BITS];
            r3_int   <= r2_int;
            r3_neg   <= r2_neg;
            r3_pos   <= r2_pos;
            r3_early <= r2_early;
        end
        if (adv4) begin
            r4_value <= n_value;
            r4_pos   <= r3_pos;
            r4_early <= r3_early;
        end
    end

    assign o_out.valid         = r4_v;
    assign o_out.value         = r4_value;
    assign o_out.stop_position = r4_pos;
    assign o_out.stopped_early = r4_early;

    a_scaled_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_v |-> (r2_scaled < dtfp_pkg::SCALED_LIMIT))
        else $error("scaled fraction exceeds eight digits");

    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_v |-> (r3_quo <= dtfp_pkg::QUO_MAX))
        else $error("fraction bits out of range");

    a_mag_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_v |-> (mag[MAG_BITS] == 1'b0))
        else $error("magnitude overflows 31 bits");

endmodule
